[hdl/sbfph_pkg.sv]
// ----------------------------------------------------------------------------
// sbfph_pkg
// types and constant tables for the spectrum bar falloff and peak hold meter
// ----------------------------------------------------------------------------
package sbfph_pkg;

    localparam int unsigned BAR_W   = 12;
    localparam int unsigned PEAK_W  = 13;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned FALL_W  = 11;
    localparam int unsigned GROW_W  = 9;
    localparam int unsigned SEL_W   = 3;

    localparam logic [SPEED_W-1:0] PEAK_SPEED_INIT = 16'd768;
    localparam logic [3:0]         LEVEL_MAX       = 4'd15;

    typedef enum logic [0:0] {
        CFG_BAR_FALL    = 1'b0,
        CFG_PEAK_GROWTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [BAR_W-1:0]   bar;
        logic [PEAK_W-1:0]  peak;
        logic [SPEED_W-1:0] speed;
    } band_state_t;

    function automatic logic [FALL_W-1:0] bar_fall(input logic [SEL_W-1:0] sel);
        logic [FALL_W-1:0] r;
        case (sel)
            3'd0:    r = 11'd97;
            3'd1:    r = 11'd216;
            3'd2:    r = 11'd384;
            3'd3:    r = 11'd512;
            default: r = 11'd1024;
        endcase
        return r;
    endfunction

    function automatic logic [GROW_W-1:0] peak_growth(input logic [SEL_W-1:0] sel);
        logic [GROW_W-1:0] r;
        case (sel)
            3'd0:    r = 9'd282;
            3'd1:    r = 9'd294;
            3'd2:    r = 9'd320;
            3'd3:    r = 9'd358;
            default: r = 9'd448;
        endcase
        return r;
    endfunction

endpackage

[hdl/sbfph_state_ram.sv]
// ----------------------------------------------------------------------------
// sbfph_state_ram
// per-band state memory, one read and one write port, registered read with
// write-first bypass and per-entry valid bits that read as zero state
// ----------------------------------------------------------------------------
module sbfph_state_ram #(
    parameter int unsigned DEPTH  = 75,
    parameter int unsigned ADDR_W = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output sbfph_pkg::band_state_t    rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  sbfph_pkg::band_state_t    wr_data
);
    import sbfph_pkg::*;

    band_state_t mem [DEPTH];
    logic [DEPTH-1:0] entry_valid_reg;
    band_state_t rd_data_reg;
    logic rd_valid_reg;
    logic same_addr;

    assign same_addr = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= same_addr ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= same_addr || entry_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hdl/sbfph_update.sv]
// ----------------------------------------------------------------------------
// sbfph_update
// bar falloff and peak raise on the read data, then a registered stage that
// decays the peak, grows the speed and writes the band state back
// ----------------------------------------------------------------------------
module sbfph_update #(
    parameter int unsigned ADDR_W = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic                      in_range,
    input  logic [ADDR_W-1:0]         addr,
    input  logic [7:0]                level,
    input  sbfph_pkg::band_state_t    cur,
    input  logic [2:0]                fall_sel,
    input  logic [2:0]                growth_sel,
    output logic [3:0]                bar_height,
    output logic [4:0]                peak_row,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output sbfph_pkg::band_state_t    wr_data
);
    import sbfph_pkg::*;

    logic [3:0]          lvl;
    logic [BAR_W-1:0]    target;
    logic signed [13:0]  fallen;
    logic [BAR_W-1:0]    bar;
    logic [PEAK_W-1:0]   bar_plus;
    logic                raise;
    logic [PEAK_W-1:0]   peak;
    logic [SPEED_W-1:0]  speed;

    logic                wb_valid_reg;
    logic [ADDR_W-1:0]   wb_addr_reg;
    logic [BAR_W-1:0]    wb_bar_reg;
    logic [PEAK_W-1:0]   wb_peak_reg;
    logic [SPEED_W-1:0]  wb_speed_reg;

    logic [7:0]          dec;
    logic [PEAK_W-1:0]   peak_next;
    logic [24:0]         product;
    logic [SPEED_W-1:0]  speed_next;

    always_comb begin
        lvl      = (level > 8'(LEVEL_MAX)) ? LEVEL_MAX : level[3:0];
        target   = {lvl, 8'd0};
        fallen   = $signed({2'b00, cur.bar}) - $signed({3'b000, bar_fall(fall_sel)});
        bar      = (fallen <= $signed({2'b00, target})) ? target : fallen[BAR_W-1:0];
        bar_plus = {1'b0, bar} + 13'd256;
        raise    = cur.peak <= bar_plus;
        peak     = raise ? bar_plus : cur.peak;
        speed    = raise ? PEAK_SPEED_INIT : cur.speed;
    end

    assign bar_height = in_range ? bar[11:8] : 4'd0;
    assign peak_row   = in_range ? peak[12:8] : 5'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else begin
            wb_valid_reg <= load && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            wb_addr_reg  <= addr;
            wb_bar_reg   <= bar;
            wb_peak_reg  <= peak;
            wb_speed_reg <= speed;
        end
    end

    always_comb begin
        dec        = wb_speed_reg[15:8];
        peak_next  = (wb_peak_reg > 13'(dec)) ? wb_peak_reg - 13'(dec) : '0;
        product    = 25'(wb_speed_reg) * 25'(peak_growth(growth_sel));
        speed_next = (product[24] == 1'b1) ? 16'hFFFF : product[23:8];
    end

    assign wr_en         = wb_valid_reg;
    assign wr_addr       = wb_addr_reg;
    assign wr_data.bar   = wb_bar_reg;
    assign wr_data.peak  = peak_next;
    assign wr_data.speed = speed_next;

endmodule

[hdl/spectrum_bar_falloff_peak_hold_top.sv]
// ----------------------------------------------------------------------------
// spectrum_bar_falloff_peak_hold_top
// per-band level meter: falling bar with selectable fall rate, held peak
// with accelerating decay
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one item per band update (band, level); m_ channel gives
//   one item back per input item (band_out, bar_height, peak_row), in order.
//   cfg channel writes register 0 (bar fall select) or 1 (peak growth
//   select); cfg_ready is always high, write only while the block is idle.
//   an item is accepted and its band state is read from memory into the
//   read register; once the output register is free the result enters it.
//   a new item is taken only after the previous one has moved into the
//   output register; the state write-back overlaps the next read and
//   is bypassed into it when the band matches.
//   bands at or above BAND_COUNT leave the state alone and return zeros.
//   reset clears the config registers and marks every band as zero state at
//   once, no clearing pass; a stalled m_ready holds the result and blocks
//   s_ready after one more item is taken.
// ----------------------------------------------------------------------------
module spectrum_bar_falloff_peak_hold_top #(
    parameter int unsigned BAND_COUNT = 75
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_band,
    input  logic [7:0] s_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_band_out,
    output logic [3:0] m_bar_height,
    output logic [4:0] m_peak_row,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [2:0] cfg_data
);
    import sbfph_pkg::*;

    localparam int unsigned ADDR_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    logic [2:0] fall_sel_reg;
    logic [2:0] growth_sel_reg;

    logic              s1_valid_reg;
    logic [6:0]        s1_band_reg;
    logic [7:0]        s1_level_reg;
    logic              s1_in_range_reg;

    logic              m_valid_reg;
    logic [6:0]        m_band_reg;
    logic [3:0]        m_bar_reg;
    logic [4:0]        m_peak_reg;

    logic              accept;
    logic              advance;
    logic              in_range;
    band_state_t       rd_data;
    logic [3:0]        bar_height;
    logic [4:0]        peak_row;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    band_state_t       wr_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = !s1_valid_reg;
    assign accept    = s_valid && s_ready;
    assign advance   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign in_range  = 32'(s_band) < BAND_COUNT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_sel_reg   <= '0;
            growth_sel_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_BAR_FALL:    fall_sel_reg   <= cfg_data;
                CFG_PEAK_GROWTH: growth_sel_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_band_reg     <= s_band;
            s1_level_reg    <= s_level;
            s1_in_range_reg <= in_range;
        end
        if (advance) begin
            m_band_reg <= s1_band_reg;
            m_bar_reg  <= bar_height;
            m_peak_reg <= peak_row;
        end
    end

    sbfph_state_ram #(
        .DEPTH  (BAND_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept && in_range),
        .rd_addr (ADDR_W'(s_band)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sbfph_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .in_range   (s1_in_range_reg),
        .addr       (ADDR_W'(s1_band_reg)),
        .level      (s1_level_reg),
        .cur        (rd_data),
        .fall_sel   (fall_sel_reg),
        .growth_sel (growth_sel_reg),
        .bar_height (bar_height),
        .peak_row   (peak_row),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign m_valid      = m_valid_reg;
    assign m_band_out   = m_band_reg;
    assign m_bar_height = m_bar_reg;
    assign m_peak_row   = m_peak_reg;

endmodule

[dv/tb_spectrum_bar_falloff_peak_hold_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectrum_bar_falloff_peak_hold_top
// self-checking bench for the per-band falling bar and peak hold meter: a
// queue-fed driver offers band/level items with random gaps, a monitor checks
// every result against an in-bench meter model, and the fall and growth
// selects are swept between phases, including out-of-range select codes
// ----------------------------------------------------------------------------
module tb_spectrum_bar_falloff_peak_hold_top;
    import sbfph_pkg::*;

    localparam int BAND_N    = 75;
    localparam int HOLD_LEN  = 400;
    localparam int QUIET_MAX = 3000;
    localparam int SETTLE    = 4;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 235;

    typedef struct packed {
        logic [6:0] band;
        logic [7:0] level;
    } level_item_t;

    typedef struct packed {
        logic [6:0] band;
        logic [3:0] height;
        logic [4:0] row;
    } meter_out_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [6:0] s_band    = '0;
    logic [7:0] s_level   = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [6:0] m_band_out;
    logic [3:0] m_bar_height;
    logic [4:0] m_peak_row;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [2:0] cfg_data  = '0;

    spectrum_bar_falloff_peak_hold_top #(
        .BAND_COUNT(BAND_N)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_band(s_band),
        .s_level(s_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_band_out(m_band_out),
        .m_bar_height(m_bar_height),
        .m_peak_row(m_peak_row),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // meter model state
    logic [BAR_W-1:0]   bar_lvl  [BAND_N];
    logic [PEAK_W-1:0]  peak_val [BAND_N];
    logic [SPEED_W-1:0] peak_spd [BAND_N];
    logic [2:0]         fall_sel   = '0;
    logic [2:0]         growth_sel = '0;
    int                 fall_rate   [5] = '{97, 216, 384, 512, 1024};
    int                 growth_rate [5] = '{282, 294, 320, 358, 448};

    level_item_t pending [$];
    meter_out_t  meter_expected [$];
    int          hot_band [4];
    int          errors     = 0;
    logic        gaps_on    = 1'b1;
    logic        hold_armed = 1'b0;
    logic        in_taken   = 1'b0;
    int          send_gap   = 0;
    int          stall_left = 0;
    int          hold_cnt   = 0;
    int          quiet      = 0;

    function automatic meter_out_t meter_update(input logic [6:0] band,
                                                input logic [7:0] level);
        meter_out_t r;
        int lvl;
        int fallen;
        int bar;
        int pk;
        int spd;
        int dec;
        longint grown;
        r.band   = band;
        r.height = '0;
        r.row    = '0;
        if (band >= BAND_N) begin
            return r;
        end
        lvl    = (level > 8'd15) ? 15 : int'(level);
        fallen = int'(bar_lvl[band]) - fall_rate[(fall_sel > 3'd4) ? 4 : fall_sel];
        bar    = (fallen <= lvl * 256) ? lvl * 256 : fallen;
        bar    = bar & 12'hFFF;
        bar_lvl[band] = BAR_W'(bar);
        pk  = int'(peak_val[band]);
        spd = int'(peak_spd[band]);
        if (pk <= bar + 256) begin
            pk  = bar + 256;
            spd = 768;
        end
        r.height = 4'(bar >> 8);
        r.row    = 5'(pk >> 8);
        dec = spd >> 8;
        pk  = (pk > dec) ? pk - dec : 0;
        peak_val[band] = PEAK_W'(pk);
        grown = (longint'(spd) * growth_rate[(growth_sel > 3'd4) ? 4 : growth_sel]) >> 8;
        if (grown > 65535) begin
            grown = 65535;
        end
        peak_spd[band] = SPEED_W'(grown);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_item(input int b, input int l);
        level_item_t it;
        it.band  = 7'(b);
        it.level = 8'(l);
        pending.push_back(it);
    endfunction

    // bursts on a few hot bands: a hit, then lower, equal or zero levels so the bar
    // falls and the peak decays, mixed with stray and out-of-range bands
    task automatic queue_random(input int count);
        int made;
        int mode;
        int n;
        int b;
        int top;
        made = 0;
        while (made < count) begin
            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                b   = hot_band[$urandom_range(0, 3)];
                n   = $urandom_range(3, 12);
                top = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 255)
                                                  : $urandom_range(6, 15);
                queue_item(b, top);
                made++;
                for (int k = 1; k < n; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        queue_item(b, 0);
                    end else begin
                        queue_item(b, $urandom_range(0, (top > 15) ? 15 : top));
                    end
                    made++;
                end
            end else if (mode < 85) begin
                queue_item($urandom_range(0, BAND_N - 1), $urandom_range(0, 255));
                made++;
            end else begin
                queue_item($urandom_range(BAND_N, 127), $urandom_range(0, 255));
                made++;
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [2:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        if (idx == CFG_BAR_FALL) begin
            fall_sel = val;
        end else begin
            growth_sel = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || s_valid || meter_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // input side: acceptance and prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                meter_expected.push_back(meter_update(s_band, s_level));
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        level_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (in_taken || !s_valid) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending.size() != 0) begin
                it = pending.pop_front();
                s_valid <= 1'b1;
                s_band  <= it.band;
                s_level <= it.level;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_armed && hold_cnt < HOLD_LEN) begin
            m_ready <= 1'b0;
            hold_cnt++;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        meter_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (meter_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected item band_out %0d bar_height %0d peak_row %0d",
                         $time, m_band_out, m_bar_height, m_peak_row);
            end else begin
                want = meter_expected.pop_front();
                if (m_band_out !== want.band) begin
                    errors++;
                    $display("%0t: band_out expected %0d actual %0d",
                             $time, want.band, m_band_out);
                end
                if (m_bar_height !== want.height) begin
                    errors++;
                    $display("%0t: bar_height band %0d expected %0d actual %0d",
                             $time, want.band, want.height, m_bar_height);
                end
                if (m_peak_row !== want.row) begin
                    errors++;
                    $display("%0t: peak_row band %0d expected %0d actual %0d",
                             $time, want.band, want.row, m_peak_row);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_MAX) begin
                $display("%0t: timeout, %0d items still expected", $time,
                         meter_expected.size());
                $display("tb_spectrum_bar_falloff_peak_hold_top failed");
                $finish;
            end
        end
    end

    int fall_plan   [PHASES] = '{4, 1, 3, 2, 7, 0, 5, 6};
    int growth_plan [PHASES] = '{0, 2, 1, 3, 5, 4, 6, 7};

    initial begin
        foreach (bar_lvl[i]) begin
            bar_lvl[i]  = '0;
            peak_val[i] = '0;
            peak_spd[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, clamping, out-of-range bands, peak hold
        write_reg(CFG_BAR_FALL, 3'd0);
        write_reg(CFG_PEAK_GROWTH, 3'd7);
        @(posedge aclk);
        queue_item(0, 0);
        queue_item(0, 255);
        queue_item(0, 16);
        queue_item(0, 15);
        queue_item(74, 15);
        queue_item(75, 200);
        queue_item(127, 255);
        queue_item(74, 1);
        queue_item(1, 8);
        queue_item(1, 8);
        queue_item(2, 15);
        repeat (10) queue_item(2, 0);
        queue_item(2, 15);
        queue_item(42, 85);
        queue_item(85, 170);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_BAR_FALL, 3'(fall_plan[p]));
            write_reg(CFG_PEAK_GROWTH, 3'(growth_plan[p]));
            @(posedge aclk);
            gaps_on = (p != 3 && p != 6);
            if (p == 2) begin
                hold_armed = 1'b1;
            end
            foreach (hot_band[i]) begin
                hot_band[i] = $urandom_range(0, BAND_N - 1);
            end
            if (p == 0) begin
                hot_band[0] = 0;
                hot_band[1] = BAND_N - 1;
            end
            queue_random(PER_PHASE);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && meter_expected.size() == 0) begin
            $display("tb_spectrum_bar_falloff_peak_hold_top passed");
        end else begin
            $display("tb_spectrum_bar_falloff_peak_hold_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/sbfph_pkg.sv
hdl/sbfph_state_ram.sv
hdl/sbfph_update.sv
hdl/spectrum_bar_falloff_peak_hold_top.sv
dv/tb_spectrum_bar_falloff_peak_hold_top.sv
